@@ design/chd_pkg.sv @@
// Shared types, constants and helpers for the chunked body decoder.
`timescale 1ns / 1ps

package chd_pkg;

	// Width of the chunk size accumulator and the byte countdown.
	localparam int SIZE_BITS = 32;

	// Stream widths.
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 16;
	localparam int STATUS_W    = 3;

	// Depth of the queue between the classifier and the parser.
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// Characters with a meaning in the chunk framing.
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_SEMI = 8'h3B;

	// Byte classes found by the front end.
	typedef enum logic [2:0] {
		CLS_HEX,
		CLS_SEMI,
		CLS_CR,
		CLS_LF,
		CLS_OTHER
	} cls_t;

	// Status codes reported once per body.
	typedef enum logic [STATUS_W-1:0] {
		ST_DONE        = 3'd0,
		ST_NO_LINE_END = 3'd1,
		ST_BAD_SIZE    = 3'd2,
		ST_TRUNCATED   = 3'd3,
		ST_BAD_DELIM   = 3'd4
	} status_t;

	// Parser phases.
	typedef enum logic [3:0] {
		PH_DIGITS,
		PH_DIGITS_CR,
		PH_EXT,
		PH_EXT_CR,
		PH_BAD,
		PH_BAD_CR,
		PH_DATA,
		PH_DATA_CR,
		PH_DATA_LF,
		PH_TRL_START,
		PH_TRL_START_CR,
		PH_TRL_MID,
		PH_TRL_MID_CR,
		PH_DROP
	} phase_t;

	// One classified byte as it travels through the queue.
	typedef struct packed {
		logic [7:0] data;
		logic       eob;
		cls_t       cls;
		logic [3:0] digit;
	} item_t;

	// Queue fill status seen by both neighbors.
	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	// Hex digit value of a byte; only meaningful for CLS_HEX.
	function automatic logic [3:0] hex_nibble(input logic [7:0] b);
		logic [7:0] v;
		begin
			if (b >= 8'h30 && b <= 8'h39) begin
				v = b - 8'h30;
			end else if (b >= 8'h61 && b <= 8'h66) begin
				v = b - 8'h57;
			end else begin
				v = b - 8'h37;
			end
			return v[3:0];
		end
	endfunction

	// Byte class used by the parser.
	function automatic cls_t classify(input logic [7:0] b);
		begin
			if ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
				(b >= 8'h41 && b <= 8'h46)) begin
				return CLS_HEX;
			end else if (b == CH_SEMI) begin
				return CLS_SEMI;
			end else if (b == CH_CR) begin
				return CLS_CR;
			end else if (b == CH_LF) begin
				return CLS_LF;
			end
			return CLS_OTHER;
		end
	endfunction

endpackage

@@ design/chd_front.sv @@
// Front end: accepts raw body bytes, classifies them and feeds the queue.
`timescale 1ns / 1ps

module chd_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [chd_pkg::IN_TDATA_W-1:0]    s_tdata,
	input  logic                              s_tlast,
	input  chd_pkg::q_status_t                q_status,
	output logic                              push,
	output chd_pkg::item_t                    push_item
);
	import chd_pkg::*;

	logic  vld_s1;
	item_t item_s1;

	// The stage empties whenever the queue has room.
	assign push     = vld_s1 && !q_status.full;
	assign s_tready = !vld_s1 || !q_status.full;
	assign push_item = item_s1;

	// Stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	// Classified request held for the queue.
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.data  <= s_tdata;
			item_s1.eob   <= s_tlast;
			item_s1.cls   <= classify(s_tdata);
			item_s1.digit <= hex_nibble(s_tdata);
		end
	end

endmodule

@@ design/chd_queue.sv @@
// Short queue of classified bytes between the front end and the parser.
`timescale 1ns / 1ps

module chd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  chd_pkg::item_t     push_item,
	input  logic               pop,
	output chd_pkg::item_t     head,
	output chd_pkg::q_status_t status
);
	import chd_pkg::*;

	item_t              entry_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	assign head         = entry_q[rd_ptr_q];
	assign status.empty = (count_q == '0);
	assign status.full  = (count_q == Q_CNT_W'(Q_DEPTH));

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + Q_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - Q_CNT_W'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

@@ design/chd_back.sv @@
// Back end: chunk framing state machine and the registered result stage.
`timescale 1ns / 1ps

module chd_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  chd_pkg::item_t                    head,
	input  chd_pkg::q_status_t                q_status,
	output logic                              pop,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [chd_pkg::OUT_TDATA_W-1:0]   m_tdata,
	output logic                              m_tuser,
	output logic                              m_tlast
);
	import chd_pkg::*;

	phase_t               phase_q, phase_d;
	logic [SIZE_BITS-1:0] acc_q, acc_d;
	logic [SIZE_BITS-1:0] left_q, left_d;
	logic                 seen_q, seen_d;
	logic                 ovf_q, ovf_d;

	logic                 res_valid, res_fin, res_payload;
	status_t              res_code;

	logic                 out_valid_q;
	logic [7:0]           out_byte_q;
	logic                 out_payload_q;
	logic                 out_fin_q;
	status_t              out_code_q;

	logic                 is_cr, is_lf, is_semi, is_hex, eob;
	logic                 out_free;

	assign is_cr   = (head.cls == CLS_CR);
	assign is_lf   = (head.cls == CLS_LF);
	assign is_semi = (head.cls == CLS_SEMI);
	assign is_hex  = (head.cls == CLS_HEX);
	assign eob     = head.eob;

	// One request leaves the queue per cycle while the result slot is free.
	assign out_free = !out_valid_q || m_tready;
	assign pop      = !q_status.empty && out_free;

	// Result of the current request.
	always_comb begin
		res_fin     = 1'b0;
		res_payload = 1'b0;
		res_code    = ST_DONE;
		unique case (phase_q)
			PH_DIGITS, PH_EXT, PH_BAD: begin
				res_fin  = eob;
				res_code = ST_NO_LINE_END;
			end
			PH_DIGITS_CR, PH_EXT_CR, PH_BAD_CR: begin
				if (is_lf) begin
					if (phase_q == PH_BAD_CR || !seen_q || ovf_q) begin
						res_fin  = 1'b1;
						res_code = ST_BAD_SIZE;
					end else begin
						res_fin  = eob;
						res_code = ST_TRUNCATED;
					end
				end else begin
					res_fin  = eob;
					res_code = ST_NO_LINE_END;
				end
			end
			PH_DATA: begin
				if (eob) begin
					res_fin  = 1'b1;
					res_code = (left_q > SIZE_BITS'(1)) ? ST_TRUNCATED : ST_BAD_DELIM;
				end else begin
					res_payload = 1'b1;
				end
			end
			PH_DATA_CR: begin
				res_fin  = !is_cr || eob;
				res_code = ST_BAD_DELIM;
			end
			PH_DATA_LF: begin
				if (!is_lf) begin
					res_fin  = 1'b1;
					res_code = ST_BAD_DELIM;
				end else begin
					res_fin  = eob;
					res_code = ST_NO_LINE_END;
				end
			end
			PH_TRL_START_CR: begin
				if (is_lf) begin
					res_fin  = 1'b1;
					res_code = ST_DONE;
				end else begin
					res_fin  = eob;
					res_code = ST_TRUNCATED;
				end
			end
			PH_TRL_START, PH_TRL_MID, PH_TRL_MID_CR: begin
				res_fin  = eob;
				res_code = ST_TRUNCATED;
			end
			PH_DROP: begin
				res_fin = 1'b0;
			end
			default: begin
				res_fin = 1'b0;
			end
		endcase
		res_valid = res_fin || res_payload;
	end

	// Next phase and datapath state.
	always_comb begin
		phase_d = phase_q;
		acc_d   = acc_q;
		left_d  = left_q;
		seen_d  = seen_q;
		ovf_d   = ovf_q;
		unique case (phase_q)
			PH_DIGITS: begin
				if (is_hex) begin
					seen_d = 1'b1;
					if (!ovf_q) begin
						// Another digit would not fit when the top nibble is in use.
						if (acc_q[SIZE_BITS-1 -: 4] != 4'h0) begin
							ovf_d = 1'b1;
						end else begin
							acc_d = {acc_q[SIZE_BITS-5:0], head.digit};
						end
					end
				end else if (is_semi) begin
					phase_d = PH_EXT;
				end else if (is_cr) begin
					phase_d = PH_DIGITS_CR;
				end else begin
					phase_d = PH_BAD;
				end
			end
			PH_EXT: begin
				if (is_cr) begin
					phase_d = PH_EXT_CR;
				end
			end
			PH_BAD: begin
				if (is_cr) begin
					phase_d = PH_BAD_CR;
				end
			end
			PH_DIGITS_CR, PH_EXT_CR, PH_BAD_CR: begin
				if (is_lf) begin
					// Good size line: start the chunk or the trailer.
					acc_d  = '0;
					seen_d = 1'b0;
					if (acc_q == '0) begin
						phase_d = PH_TRL_START;
					end else begin
						left_d  = acc_q;
						phase_d = PH_DATA;
					end
				end else if (phase_q == PH_EXT_CR) begin
					phase_d = is_cr ? PH_EXT_CR : PH_EXT;
				end else begin
					phase_d = is_cr ? PH_BAD_CR : PH_BAD;
				end
			end
			PH_DATA: begin
				if (left_q != '0) begin
					left_d = left_q - SIZE_BITS'(1);
				end
				if (left_q <= SIZE_BITS'(1)) begin
					phase_d = PH_DATA_CR;
				end
			end
			PH_DATA_CR: begin
				phase_d = PH_DATA_LF;
			end
			PH_DATA_LF: begin
				phase_d = PH_DIGITS;
			end
			PH_TRL_START: begin
				phase_d = is_cr ? PH_TRL_START_CR : PH_TRL_MID;
			end
			PH_TRL_START_CR: begin
				phase_d = is_cr ? PH_TRL_MID_CR : PH_TRL_MID;
			end
			PH_TRL_MID: begin
				if (is_cr) begin
					phase_d = PH_TRL_MID_CR;
				end
			end
			PH_TRL_MID_CR: begin
				if (is_lf) begin
					phase_d = PH_TRL_START;
				end else if (!is_cr) begin
					phase_d = PH_TRL_MID;
				end
			end
			PH_DROP: begin
				phase_d = PH_DROP;
			end
			default: begin
				phase_d = PH_DROP;
			end
		endcase
		// A status or the end of a dropped body overrides the normal step.
		if (eob && (res_fin || phase_q == PH_DROP)) begin
			phase_d = PH_DIGITS;
			acc_d   = '0;
			left_d  = '0;
			seen_d  = 1'b0;
			ovf_d   = 1'b0;
		end else if (res_fin) begin
			phase_d = PH_DROP;
		end
	end

	// Parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DIGITS;
			acc_q   <= '0;
			left_q  <= '0;
			seen_q  <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (pop) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			left_q  <= left_d;
			seen_q  <= seen_d;
			ovf_q   <= ovf_d;
		end
	end

	// Result slot valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= pop && res_valid;
		end
	end

	// Result slot payload.
	always_ff @(posedge clk) begin
		if (pop && res_valid) begin
			out_byte_q    <= res_payload ? head.data : 8'h00;
			out_payload_q <= res_payload;
			out_fin_q     <= res_fin;
			out_code_q    <= res_fin ? res_code : ST_DONE;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W - 8 - STATUS_W){1'b0}}, out_code_q, out_byte_q};
	assign m_tuser  = out_payload_q;
	assign m_tlast  = out_fin_q;

endmodule

@@ design/http_chunked_body_decoder_top.sv @@
// Top level of the chunked transfer body decoder.
//
//  channel | dir | tdata (low bit up)            | tuser          | tlast
//  s_*     | in  | body_byte[7:0]                | -              | end_of_body
//  m_*     | out | out_byte[7:0], status_code    | payload_valid  | finished
//          |     | [10:8], zeros [15:11]         |                |
//
// One body byte per cycle is sustained: the parser takes one queued request a
// cycle whenever the result register is empty or being read.
// A result is offered once its byte has passed the classifier register, the queue
// and the result register, in that order; a stall can hold it at any of them.
// Reset is asynchronous and needs no clearing pass; the block is ready right away.
// A stall on the result side fills the four-entry queue before input stalls.
`timescale 1ns / 1ps

module http_chunked_body_decoder_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [chd_pkg::IN_TDATA_W-1:0]    s_tdata,   // body_byte[7:0]
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [chd_pkg::OUT_TDATA_W-1:0]   m_tdata,   // out_byte[7:0], status_code[10:8]
	output logic                              m_tuser,   // payload_valid
	output logic                              m_tlast
);
	import chd_pkg::*;

	logic      push, pop;
	item_t     push_item, head;
	q_status_t q_status;

	// Classifier.
	chd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.q_status  (q_status),
		.push      (push),
		.push_item (push_item)
	);

	// Decoupling queue.
	chd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	// Framing parser and result register.
	chd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_status (q_status),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// Every result is either a payload byte or a status, never both.
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser != m_tlast))
		else $error("result is neither or both payload and status");

	// Status codes stay within the defined set.
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tdata[10:8] <= ST_BAD_DELIM))
		else $error("undefined status code");

	// Fields of the other kind are zero.
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tuser || m_tdata[7:0] == 8'h00) &&
			(m_tlast || m_tdata[10:8] == ST_DONE)))
		else $error("unused result field not zero");

	// The queue is never full and empty at once.
	a_queue_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_status.full && q_status.empty))
		else $error("queue status inconsistent");

endmodule
